// File: sv/state_confirm_filter_with_led_status_core_assert.svh
// Assertion macros for the state confirm filter core.
// Included by the top level; needs i_clk and i_rst_n in the including module.
`ifndef STATE_CONFIRM_FILTER_WITH_LED_STATUS_CORE_ASSERT_SVH
`define STATE_CONFIRM_FILTER_WITH_LED_STATUS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/scf_pkg.sv
// Package for the state confirm filter core: types, defaults, register indexes.
// No dependencies.
package scf_pkg;

    localparam int TIME_BITS_DEF  = 48;
    localparam int COUNT_BITS_DEF = 4;

    localparam int CONFIRM_BITS = 4;
    localparam int HOLD_BITS    = 24;
    localparam int CLASS_BITS   = 2;

    localparam logic [CONFIRM_BITS-1:0] CONFIRM_RST   = 4'd3;
    localparam logic [HOLD_BITS-1:0]    MIN_HOLD_RST  = 24'd1200000;
    localparam logic [HOLD_BITS-1:0]    EVT_HOLD_RST  = 24'd2000000;
    localparam logic                    LED_LEVEL_RST = 1'b0;

    localparam logic [CLASS_BITS-1:0] CLASS_NONE = 2'd0;

    // Bit of the class code that flags an unknown face (codes 2 and 3).
    localparam int UNKNOWN_BIT = 1;

    typedef enum logic [1:0] {
        CFG_CONFIRM_FRAMES = 2'd0,
        CFG_MIN_HOLD_US    = 2'd1,
        CFG_EVENT_HOLD_US  = 2'd2,
        CFG_LED_ON_LEVEL   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic yellow;
        logic blue;
        logic red;
        logic green;
    } t_led_lit;

endpackage

// File: sv/state_confirm_filter_with_led_status_core.sv
// Top level of the state confirm filter: N-frame confirm with minimum hold
// and priority status LED selection. Depends on scf_pkg and the assert header.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-------------------------------------------
//  input   | i_in_valid  | o_in_ready  | i_now_time, i_raw_class, i_enroll_done,
//          |             |             | i_store_changed
//  result  | o_out_valid | i_out_ready | o_stable_class, o_red_pin, o_green_pin,
//          |             |             | o_blue_pin, o_yellow_pin
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// One frame per cycle unless the result stalls; path: input register, then result register.
// All frame work (hold end add, elapsed-time subtract, count/compare, LED priority)
// sits between the input register and the result register.
// Synchronous active-low reset loads config defaults and clears filter state.
// A stalled result holds the result register; the input register still takes a
// transaction when the result is consumed in the same cycle.
// Config writes are always taken (o_cfg_ready tied high).
`include "state_confirm_filter_with_led_status_core_assert.svh"

module state_confirm_filter_with_led_status_core
    import scf_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [TIME_BITS-1:0]  i_now_time,
    input  logic [CLASS_BITS-1:0] i_raw_class,
    input  logic                  i_enroll_done,
    input  logic                  i_store_changed,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CLASS_BITS-1:0] o_stable_class,
    output logic                  o_red_pin,
    output logic                  o_green_pin,
    output logic                  o_blue_pin,
    output logic                  o_yellow_pin,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [HOLD_BITS-1:0]  i_cfg_data
);

    // Width for count vs. threshold compare: wide enough for both.
    localparam int CMP_W = (COUNT_BITS > CONFIRM_BITS) ? COUNT_BITS : CONFIRM_BITS;
    localparam int TW1   = TIME_BITS + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // ---------------- configuration registers ----------------
    logic [CONFIRM_BITS-1:0] r_confirm;
    logic [HOLD_BITS-1:0]    r_min_hold;
    logic [HOLD_BITS-1:0]    r_evt_hold;
    logic                    r_led_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm   <= CONFIRM_RST;
            r_min_hold  <= MIN_HOLD_RST;
            r_evt_hold  <= EVT_HOLD_RST;
            r_led_level <= LED_LEVEL_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CONFIRM_FRAMES: r_confirm   <= i_cfg_data[CONFIRM_BITS-1:0];
                CFG_MIN_HOLD_US:    r_min_hold  <= i_cfg_data;
                CFG_EVENT_HOLD_US:  r_evt_hold  <= i_cfg_data;
                CFG_LED_ON_LEVEL:   r_led_level <= i_cfg_data[0];
                default:            r_led_level <= r_led_level;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                  r_in_vld;
    logic [TIME_BITS-1:0]  r_in_now;
    logic [CLASS_BITS-1:0] r_in_raw;
    logic                  r_in_enroll;
    logic                  r_in_changed;

    logic r_out_vld;
    logic w_adv;   // frame in the input register moves to the result register

    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_now     <= i_now_time;
            r_in_raw     <= i_raw_class;
            r_in_enroll  <= i_enroll_done;
            r_in_changed <= i_store_changed;
        end
    end

    // ---------------- filter state ----------------
    logic [CLASS_BITS-1:0] r_stable;
    logic [CLASS_BITS-1:0] r_cand_val;
    logic [COUNT_BITS-1:0] r_cand_cnt;
    logic [TIME_BITS-1:0]  r_last_change;
    logic [TIME_BITS-1:0]  r_blue_end;
    logic [TIME_BITS-1:0]  r_yellow_end;

    // ---------------- frame logic ----------------
    // Event hold end = now + hold, saturating at all ones.
    logic [TW1-1:0]       w_hold_sum;
    logic [TIME_BITS-1:0] w_hold_end;
    logic [TIME_BITS-1:0] n_blue_end;
    logic [TIME_BITS-1:0] n_yellow_end;

    assign w_hold_sum   = {1'b0, r_in_now} + TW1'(r_evt_hold);
    assign w_hold_end   = w_hold_sum[TIME_BITS] ? {TIME_BITS{1'b1}}
                                                : w_hold_sum[TIME_BITS-1:0];
    assign n_yellow_end = r_in_changed ? w_hold_end : r_yellow_end;
    assign n_blue_end   = r_in_enroll  ? w_hold_end : r_blue_end;

    // Elapsed time since last change; a borrow means time went backwards.
    logic [TW1-1:0] w_elapsed;
    logic           w_hold_ok;

    assign w_elapsed = {1'b0, r_in_now} - {1'b0, r_last_change};
    assign w_hold_ok = !w_elapsed[TIME_BITS]
                    && (w_elapsed[TIME_BITS-1:0] >= TIME_BITS'(r_min_hold));

    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic                  w_switch;
    logic [CLASS_BITS-1:0] n_stable;
    logic [CLASS_BITS-1:0] n_cand_val;
    logic [COUNT_BITS-1:0] n_cand_cnt;
    logic [TIME_BITS-1:0]  n_last_change;

    assign w_cnt_inc = (r_cand_cnt == CNT_MAX) ? r_cand_cnt : r_cand_cnt + 1'b1;

    always_comb begin
        w_switch      = 1'b0;
        n_stable      = r_stable;
        n_cand_val    = r_in_raw;
        n_cand_cnt    = '0;
        n_last_change = r_last_change;
        priority if (r_in_raw == r_stable) begin
            n_cand_cnt = '0;
        end else if (r_in_raw != r_cand_val) begin
            n_cand_cnt = COUNT_BITS'(1);
        end else begin
            // repeated candidate: count up, switch once confirmed and hold passed
            w_switch = (CMP_W'(w_cnt_inc) >= CMP_W'(r_confirm)) && w_hold_ok;
            if (w_switch) begin
                n_stable      = r_in_raw;
                n_cand_cnt    = '0;
                n_last_change = r_in_now;
            end else begin
                n_cand_cnt = w_cnt_inc;
            end
        end
    end

    // LED priority: yellow hold, blue hold, unknown face, else green.
    t_led_lit n_lit;

    always_comb begin
        n_lit = '0;
        priority if (r_in_now < n_yellow_end) begin
            n_lit.yellow = 1'b1;
        end else if (r_in_now < n_blue_end) begin
            n_lit.blue = 1'b1;
        end else if (n_stable[UNKNOWN_BIT]) begin
            n_lit.red = 1'b1;
        end else begin
            n_lit.green = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= CLASS_NONE;
            r_cand_val    <= CLASS_NONE;
            r_cand_cnt    <= '0;
            r_last_change <= '0;
            r_blue_end    <= '0;
            r_yellow_end  <= '0;
        end else if (w_adv) begin
            r_stable      <= n_stable;
            r_cand_val    <= n_cand_val;
            r_cand_cnt    <= n_cand_cnt;
            r_last_change <= n_last_change;
            r_blue_end    <= n_blue_end;
            r_yellow_end  <= n_yellow_end;
        end
    end

    // ---------------- result register ----------------
    logic [CLASS_BITS-1:0] r_out_stable;
    t_led_lit              r_lit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_stable <= n_stable;
            r_lit        <= n_lit;
        end
    end

    // Pin level: lit drives the on level, unlit its inverse.
    assign o_out_valid    = r_out_vld;
    assign o_stable_class = r_out_stable;
    assign o_red_pin      = r_lit.red    ? r_led_level : !r_led_level;
    assign o_green_pin    = r_lit.green  ? r_led_level : !r_led_level;
    assign o_blue_pin     = r_lit.blue   ? r_led_level : !r_led_level;
    assign o_yellow_pin   = r_lit.yellow ? r_led_level : !r_led_level;

    // ---------------- assertions ----------------
    `SCF_ASSERT_NOW(a_one_led, r_out_vld, $onehot(r_lit), "exactly one LED must be lit")
    `SCF_ASSERT_NEXT(a_state_hold, !w_adv, $stable(r_stable) && $stable(r_cand_cnt), "filter state moved without a frame")
    `SCF_ASSERT_NEXT(a_switch_upd, w_adv && w_switch, (r_cand_cnt == '0) && (r_last_change == $past(r_in_now)), "stable switch did not clear count or stamp time")
    `SCF_ASSERT_NEXT(a_in_kept, r_in_vld && !w_adv, r_in_vld && $stable(r_in_now), "pending frame lost from input register")

endmodule
